// File: rtl/core/twhf_pkg.sv
// Shared types, constants and the quarter-wave table builder of the tone burst generator.
// No dependencies; every other file of the block imports this package.
package twhf_pkg;

  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned FADE_W  = 16;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned SINE_W  = 17;
  localparam int unsigned SAMPLE_W = 16;

  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;
  typedef logic signed [SINE_W-1:0]  sine_t;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd3;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd85704562;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd8820;
  localparam logic [FADE_W-1:0]  FADE_RESET  = 16'd441;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd149;

  localparam mul_b_t W_FUND = 18'sd53740;
  localparam mul_b_t W_HARM = 18'sd11796;
  localparam mul_b_t AMP_07 = 18'sd45875;
  localparam logic [GAIN_W-1:0] ENV_ONE = 17'h10000;
  localparam logic [15:0] SINE_PEAK = 16'd32767;

  // Entry k of a quarter-wave table with 2^qbits entries, Q1.15, from a Q2.30 series.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(k) * 64'd1686629713) >> qbits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return r[15:0];
  endfunction

endpackage

// File: rtl/core/twhf_sine.sv
// Full-wave sine lookup built on a constant quarter-wave table, with a registered result.
// Depends on twhf_pkg for the table builder and the sample types.
module twhf_sine #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned QUARTER_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  input  logic                  harm_i,
  output twhf_pkg::sine_t       val_o
);
  import twhf_pkg::*;

  localparam int unsigned QSIZE = 1 << QUARTER_TABLE_BITS;

  logic [15:0]                   rom [QSIZE];
  logic [PHASE_BITS-1:0]         p;
  logic [1:0]                    quad;
  logic [QUARTER_TABLE_BITS-1:0] idx;
  logic [QUARTER_TABLE_BITS-1:0] idx_neg;
  logic [15:0]                   mag;
  sine_t                         val_d;
  sine_t                         val_q;

  for (genvar k = 0; k < QSIZE; k++) begin : g_rom
    assign rom[k] = sine_entry(k, QUARTER_TABLE_BITS);
  end

  assign p       = harm_i ? {phase_i[PHASE_BITS-2:0], 1'b0} : phase_i;
  assign quad    = p[PHASE_BITS-1 -: 2];
  assign idx     = p[PHASE_BITS-3 -: QUARTER_TABLE_BITS];
  assign idx_neg = ~idx + QUARTER_TABLE_BITS'(1);

  always_comb begin
    if (quad[0]) begin
      mag = (idx == '0) ? SINE_PEAK : rom[idx_neg];
    end else begin
      mag = rom[idx];
    end
    val_d = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// File: rtl/core/twhf_mul.sv
// Shared signed multiplier of the sample pipeline, with a registered product.
// Depends on twhf_pkg for the operand and product types.
module twhf_mul (
  input  logic             clk_i,
  input  logic             en_i,
  input  twhf_pkg::mul_a_t a_i,
  input  twhf_pkg::mul_b_t b_i,
  output twhf_pkg::mul_p_t prod_o
);
  import twhf_pkg::*;

  mul_p_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/tone_with_harmonic_and_fade.sv
// Tone burst generator: a sequencer that drives the sine lookup and the shared multiplier.
// Depends on twhf_pkg, twhf_sine and twhf_mul.
//
// Each accepted beat produces the next sample of a sine tone with an added second
// harmonic, scaled by 0.7 and by a linear fade-in and fade-out envelope; a beat with
// restart high begins a new burst of total_samples samples, and the final sample carries
// last. A sample enters the output register in S_OUT, after states S_MENV, S_MF, S_MH,
// S_MIX, S_MAMP, S_ASCL and S_MENVF, in which five products pass in turn through the
// one shared multiplier; S_OUT waits while the output holds an untaken sample, and the
// input stays closed until then. A beat that yields no sample (no burst running, an empty
// burst, or a burst cut short by a smaller total_samples) leaves the input open. The user
// must write registers only while the block is idle; the block does not enforce this.
module tone_with_harmonic_and_fade #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned QUARTER_TABLE_BITS = 8,
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [twhf_pkg::SAMPLE_W-1:0] sample_o,
  output logic                               last_o,
  input  logic                               cfg_we_i,
  input  logic [twhf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [twhf_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import twhf_pkg::*;

  localparam int unsigned CW = ((INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MENV  = 4'd1;
  localparam logic [3:0] S_MF    = 4'd2;
  localparam logic [3:0] S_MH    = 4'd3;
  localparam logic [3:0] S_MIX   = 4'd4;
  localparam logic [3:0] S_MAMP  = 4'd5;
  localparam logic [3:0] S_ASCL  = 4'd6;
  localparam logic [3:0] S_MENVF = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [FADE_W-1:0]     fade_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic                  run_q, run_d;
  logic                  full_q, full_d;
  logic [FADE_W-1:0]     n_q, n_d;
  logic [GAIN_W-1:0]     env_q, env_d;
  mul_a_t                acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                  last_q, last_d;

  logic                  accept;
  logic                  cur_run;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [CW-1:0]         i_ext, tot_ext, fade_ext, diff, idx_next_ext;
  logic                  is_last;
  logic                  out_load;
  logic [GAIN_W-1:0]     env_sat;
  mul_p_t                rnd;
  logic                  sine_en, sine_harm;
  sine_t                 sine_val;
  logic                  mul_en;
  mul_a_t                mul_a;
  mul_b_t                mul_b;
  mul_p_t                prod;

  twhf_sine #(
    .PHASE_BITS        (PHASE_BITS),
    .QUARTER_TABLE_BITS(QUARTER_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .en_i   (sine_en),
    .phase_i(phase_q),
    .harm_i (sine_harm),
    .val_o  (sine_val)
  );

  twhf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

  assign cur_run      = restart_i || run_q;
  assign cur_idx      = restart_i ? '0 : idx_q;
  assign i_ext        = CW'(cur_idx);
  assign tot_ext      = CW'(total_q);
  assign fade_ext     = CW'(fade_q);
  assign diff         = tot_ext - i_ext;
  assign idx_next_ext = CW'(idx_q) + CW'(1);
  assign is_last      = (idx_next_ext == tot_ext);
  assign out_load     = !out_valid_q || out_ready_i;
  assign env_sat      = (prod > MUL_P_W'(ENV_ONE)) ? ENV_ONE : prod[GAIN_W-1:0];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    run_d       = run_q;
    full_d      = full_q;
    n_d         = n_q;
    env_d       = env_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    last_d      = last_q;
    sine_en     = 1'b0;
    sine_harm   = 1'b0;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rnd         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            idx_d   = '0;
            phase_d = '0;
          end
          if (!cur_run || (i_ext >= tot_ext)) begin
            run_d = 1'b0;
          end else begin
            run_d   = 1'b1;
            full_d  = !(i_ext < fade_ext) && !((i_ext + fade_ext) > tot_ext);
            n_d     = (i_ext < fade_ext) ? i_ext[FADE_W-1:0] : diff[FADE_W-1:0];
            state_d = S_MENV;
          end
        end
      end
      S_MENV: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(n_q);
        mul_b   = MUL_B_W'(gain_q);
        sine_en = 1'b1;
        state_d = S_MF;
      end
      S_MF: begin
        env_d     = full_q ? ENV_ONE : env_sat;
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(sine_val);
        mul_b     = W_FUND;
        sine_en   = 1'b1;
        sine_harm = 1'b1;
        state_d   = S_MH;
      end
      S_MH: begin
        acc_d   = $signed(prod[MUL_A_W-1:0]);
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(sine_val);
        mul_b   = W_HARM;
        state_d = S_MIX;
      end
      S_MIX: begin
        acc_d   = acc_q + $signed(prod[MUL_A_W-1:0]);
        state_d = S_MAMP;
      end
      S_MAMP: begin
        mul_en  = 1'b1;
        mul_a   = acc_q;
        mul_b   = AMP_07;
        state_d = S_ASCL;
      end
      S_ASCL: begin
        // Bias a negative product so that the shift truncates toward zero.
        rnd     = prod + (prod[MUL_P_W-1] ? MUL_P_W'(16'hFFFF) : '0);
        acc_d   = $signed(rnd[MUL_A_W+15:16]);
        state_d = S_MENVF;
      end
      S_MENVF: begin
        mul_en  = 1'b1;
        mul_a   = acc_q;
        mul_b   = $signed({1'b0, env_q});
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          rnd         = prod + (prod[MUL_P_W-1] ? MUL_P_W'(32'hFFFF_FFFF) : '0);
          sample_d    = $signed(rnd[SAMPLE_W+31:32]);
          last_d      = is_last;
          out_valid_d = 1'b1;
          idx_d       = idx_q + INDEX_BITS'(1);
          phase_d     = phase_q + PHASE_BITS'(step_q);
          if (is_last) begin
            run_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_RESET;
      total_q     <= TOTAL_RESET;
      fade_q      <= FADE_RESET;
      gain_q      <= GAIN_RESET;
      phase_q     <= '0;
      idx_q       <= INDEX_BITS'(TOTAL_RESET);
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PHASE_STEP: step_q  <= cfg_wdata_i[STEP_W-1:0];
          REG_TOTAL:      total_q <= cfg_wdata_i[TOTAL_W-1:0];
          REG_FADE:       fade_q  <= cfg_wdata_i[FADE_W-1:0];
          REG_GAIN:       gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    full_q   <= full_d;
    n_q      <= n_d;
    env_q    <= env_d;
    acc_q    <= acc_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  // The input is closed only by an accepted beat.
  a_ready_falls_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input closed without an accepted beat");

  // The envelope used for the final product never exceeds unity.
  a_env_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MENVF) |-> (env_q <= ENV_ONE))
    else $error("envelope above unity");

  // A sample flagged as last ends the burst.
  a_last_stops_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_load && is_last) |=> !run_q)
    else $error("burst still running after its last sample");

  // Samples stay within the scaled full-scale range.
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_o <= 16'sd22936) && (sample_o >= -16'sd22936))
    else $error("sample out of range");

endmodule

// File: bench/tb.sv
// Self-checking bench for the tone burst generator: a directed table of beats and register
// writes, then random bursts; hand-checked beats are held to fixed samples, all others to
// a bit-accurate tone predictor. Depends on twhf_pkg and tone_with_harmonic_and_fade.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT = 16;
  localparam int unsigned RANDOM_SAMPLES = 500;
  localparam longint MIX_FUND = 53740;
  localparam longint MIX_HARM = 11796;
  localparam longint GAIN_07 = 45875;
  localparam longint ENV_FULL = 65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               lst;
  } sample_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_e;

  typedef struct {
    row_kind_e                        kind;
    logic [twhf_pkg::CFG_IDX_W-1:0]   idx;
    logic [twhf_pkg::CFG_W-1:0]       data;
    logic                             rs;
    bit                               hand_checked;
    sample_t                          res;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               restart = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [twhf_pkg::SAMPLE_W-1:0] sample;
  logic                               last;
  logic                               cfg_we = 1'b0;
  logic [twhf_pkg::CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [twhf_pkg::CFG_W-1:0]         cfg_wdata = '0;

  logic [31:0] step_r;
  logic [23:0] total_r;
  logic [15:0] fade_r;
  logic [16:0] gain_r;
  logic [31:0] phase_r;
  logic [23:0] index_r;
  logic        run_r;
  logic [15:0] sine_rom [0:255];

  sample_t   tone_expect[$];
  stim_row_t stim_rows[$];
  sample_t   head;
  rx_mode_e  rx_mode = RX_OPEN;
  int        rx_left = 0;
  int        burst_left = 0;
  int        cycle_count = 0;
  int        mismatches = 0;
  int        beats_sent = 0;
  int        samples_sent = 0;
  int        samples_checked = 0;
  int        reg_writes = 0;

  tone_with_harmonic_and_fade u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_o    (sample),
    .last_o      (last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void build_sine_rom();
    logic [63:0] divs [0:4];
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    divs[0] = 64'd110;
    divs[1] = 64'd72;
    divs[2] = 64'd42;
    divs[3] = 64'd20;
    divs[4] = 64'd6;
    for (int k = 0; k < 256; k++) begin
      x = (64'(k) * HALF_PI_Q30) >> 8;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int j = 0; j < 5; j++) begin
        t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[j];
      end
      s = (x * t) >> 30;
      r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      sine_rom[k] = r[15:0];
    end
  endfunction

  function automatic longint quarter_wave(input logic [31:0] p);
    logic [1:0] quad;
    logic [7:0] k;
    longint     v;
    quad = p[31:30];
    k = p[29:22];
    if (quad[0]) begin
      v = (k == 8'd0) ? 32767 : longint'(sine_rom[8'd0 - k]);
    end else begin
      v = longint'(sine_rom[k]);
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic longint fade_ramp(input longint n);
    longint g;
    g = n * longint'(gain_r);
    return (g > ENV_FULL) ? ENV_FULL : g;
  endfunction

  function automatic bit next_tone_sample(input logic rs, output sample_t res);
    longint env;
    longint f;
    longint h;
    longint mix;
    longint amp;
    longint lvl;
    res = '0;
    if (rs) begin
      index_r = '0;
      phase_r = '0;
      run_r = 1'b1;
    end
    if (!run_r || index_r >= total_r) begin
      run_r = 1'b0;
      return 1'b0;
    end
    if (longint'(index_r) < longint'(fade_r)) begin
      env = fade_ramp(longint'(index_r));
    end else if (longint'(index_r) + longint'(fade_r) > longint'(total_r)) begin
      env = fade_ramp(longint'(total_r) - longint'(index_r));
    end else begin
      env = ENV_FULL;
    end
    f = quarter_wave(phase_r);
    h = quarter_wave({phase_r[30:0], 1'b0});
    mix = MIX_FUND * f + MIX_HARM * h;
    amp = (mix * GAIN_07) / 65536;
    lvl = (amp * env) / (longint'(1) << 32);
    res.smp = lvl[15:0];
    res.lst = (longint'(index_r) + 1 == longint'(total_r));
    index_r = index_r + 24'd1;
    phase_r = phase_r + step_r;
    if (res.lst) begin
      run_r = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_reg_row(input logic [twhf_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
    stim_row_t row;
    row = '{kind: ROW_REG, idx: idx, data: data, rs: 1'b0, hand_checked: 1'b0, res: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_beat_row(input logic rs);
    stim_row_t row;
    row = '{kind: ROW_BEAT, idx: '0, data: '0, rs: rs, hand_checked: 1'b0, res: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked_beat(input logic rs, input logic signed [15:0] smp,
                                           input logic lst);
    stim_row_t row;
    row = '{kind: ROW_BEAT, idx: '0, data: '0, rs: rs, hand_checked: 1'b1,
            res: '{smp: smp, lst: lst}};
    stim_rows.push_back(row);
  endfunction

  task automatic write_reg(input logic [twhf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      twhf_pkg::REG_PHASE_STEP: step_r = data;
      twhf_pkg::REG_TOTAL:      total_r = data[23:0];
      twhf_pkg::REG_FADE:       fade_r = data[15:0];
      twhf_pkg::REG_GAIN:       gain_r = data[16:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tone_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_beat(input logic rs, input bit hand_checked, input sample_t fixed_res);
    sample_t res;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    beats_sent++;
    if (next_tone_sample(rs, res)) begin
      tone_expect.push_back(hand_checked ? fixed_res : res);
      samples_sent++;
    end
  endtask

  task automatic run_random_phase();
    logic [31:0] step_v;
    logic [31:0] upper;
    logic [23:0] total_v;
    logic [15:0] fade_v;
    logic [16:0] gain_v;
    int          n_beats;
    wait_idle();
    upper = $urandom();
    case ($urandom_range(0, 5))
      0: step_v = '0;
      1: step_v = '1;
      2: step_v = 32'h4000_0000;
      default: step_v = $urandom();
    endcase
    case ($urandom_range(0, 9))
      0: total_v = '0;
      1: total_v = '1;
      2: total_v = 24'($urandom());
      default: total_v = 24'($urandom_range(1, 48));
    endcase
    case ($urandom_range(0, 7))
      0: fade_v = '0;
      1: fade_v = '1;
      2: fade_v = 16'd1;
      default: fade_v = 16'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 7))
      0: gain_v = '0;
      1: gain_v = '1;
      2: gain_v = 17'h10000;
      3: gain_v = 17'($urandom());
      default: gain_v = (fade_v == 0) ? 17'($urandom()) : 17'(65536 / fade_v);
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(twhf_pkg::REG_PHASE_STEP, step_v);
    if ($urandom_range(0, 3) != 0) write_reg(twhf_pkg::REG_TOTAL, {upper[31:24], total_v});
    if ($urandom_range(0, 3) != 0) write_reg(twhf_pkg::REG_FADE, {upper[31:16], fade_v});
    if ($urandom_range(0, 3) != 0) write_reg(twhf_pkg::REG_GAIN, {upper[31:17], gain_v});
    cfg_we <= 1'b0;
    if (total_r <= 24'd64) begin
      n_beats = int'(total_r) + $urandom_range(0, 2);
    end else begin
      n_beats = $urandom_range(8, 64);
    end
    for (int b = 0; b < n_beats; b++) begin
      if (b == 0) begin
        send_beat($urandom_range(0, 7) != 0, 1'b0, '0);
      end else begin
        send_beat($urandom_range(0, 39) == 0, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tone_expect.size() == 0) begin
        $error("sample beat with nothing pending: sample %0d last %0b", sample, last);
        mismatches++;
      end else begin
        head = tone_expect.pop_front();
        if (sample !== head.smp) begin
          $error("sample: expected %0d, got %0d", head.smp, sample);
          mismatches++;
        end
        if (last !== head.lst) begin
          $error("last: expected %0b, got %0b", head.lst, last);
          mismatches++;
        end
        samples_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int random_start;
    build_sine_rom();
    step_r = 32'd85704562;
    total_r = 24'd8820;
    fade_r = 16'd441;
    gain_r = 17'd149;
    phase_r = '0;
    index_r = 24'd8820;
    run_r = 1'b0;

    add_beat_row(1'b0);
    add_checked_beat(1'b1, 16'sd0, 1'b0);
    add_beat_row(1'b0);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd0);
    add_beat_row(1'b1);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd1);
    add_checked_beat(1'b1, 16'sd0, 1'b1);
    add_beat_row(1'b0);
    add_reg_row(twhf_pkg::REG_FADE, 32'd0);
    add_reg_row(twhf_pkg::REG_PHASE_STEP, 32'd0);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd3);
    add_checked_beat(1'b1, 16'sd0, 1'b0);
    add_checked_beat(1'b0, 16'sd0, 1'b0);
    add_checked_beat(1'b0, 16'sd0, 1'b1);
    add_reg_row(twhf_pkg::REG_PHASE_STEP, 32'h4000_0000);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd6);
    add_beat_row(1'b1);
    for (int b = 0; b < 5; b++) add_beat_row(1'b0);
    add_reg_row(twhf_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_reg_row(twhf_pkg::REG_FADE, 32'hFFFF_FFFF);
    add_reg_row(twhf_pkg::REG_GAIN, 32'hFFFF_FFFF);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'hFFFF_FFFF);
    add_checked_beat(1'b1, 16'sd0, 1'b0);
    add_beat_row(1'b0);
    add_beat_row(1'b0);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd2);
    add_beat_row(1'b0);
    add_reg_row(twhf_pkg::REG_GAIN, 32'd0);
    add_checked_beat(1'b1, 16'sd0, 1'b0);
    add_checked_beat(1'b0, 16'sd0, 1'b1);
    add_reg_row(twhf_pkg::REG_GAIN, 32'h0001_0000);
    add_reg_row(twhf_pkg::REG_FADE, 32'd1);
    add_reg_row(twhf_pkg::REG_TOTAL, 32'd4);
    add_reg_row(twhf_pkg::REG_PHASE_STEP, 32'h1234_5678);
    add_beat_row(1'b1);
    for (int b = 0; b < 3; b++) add_beat_row(1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < stim_rows.size(); k++) begin
      if (stim_rows[k].kind == ROW_REG) begin
        if (k == 0 || stim_rows[k-1].kind != ROW_REG) wait_idle();
        write_reg(stim_rows[k].idx, stim_rows[k].data);
        if (k == stim_rows.size() - 1 || stim_rows[k+1].kind != ROW_REG) cfg_we <= 1'b0;
      end else begin
        send_beat(stim_rows[k].rs, stim_rows[k].hand_checked, stim_rows[k].res);
      end
    end

    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      run_random_phase();
    end
    wait_idle();

    if (tone_expect.size() != 0) begin
      $error("%0d expected samples never arrived", tone_expect.size());
      mismatches++;
    end
    $display("Sent %0d beats across %0d register writes and compared %0d samples.",
             beats_sent, reg_writes, samples_checked);
    $display("Bursts of zero, one, short and full totals, flat and saturating fades, restarts.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
